/* sv/mm64a_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the MurmurHash64A block.
// Used by the multiplier, datapath, controller and top level; depends on nothing.
package mm64a_pkg;

    localparam logic [63:0] MUL_CONST      = 64'hc6a4a7935bd1e995;
    localparam int          MIX_SHIFT      = 47;
    localparam logic [3:0]  BYTES_PER_WORD = 4'd8;
    localparam logic [31:0] SEED_RESET     = 32'd19820125;

    // Operand picked for the shared multiplier.
    typedef enum logic [2:0] {
        SRC_LEN,
        SRC_WORD,
        SRC_K,
        SRC_H,
        SRC_HFIN
    } mul_src_t;

    // Update applied to the running hash.
    typedef enum logic [2:0] {
        H_HOLD,
        H_INIT,
        H_XORP,
        H_TAIL,
        H_PROD,
        H_FIN
    } h_op_t;

    typedef struct packed {
        logic     in_load;
        logic     mul_start;
        mul_src_t mul_src;
        logic     k_load;
        h_op_t    h_op;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic nb_full;
        logic nb_zero;
        logic last;
    } dp_status_t;

endpackage

/* sv/mm64a_mul.sv */
`timescale 1ns / 1ps
// Iterative 64-bit multiplier by the hash constant, low 64 bits of the product.
// Uses one 32x32 multiplier over the steps ST_LL, ST_LH and ST_HL; depends on mm64a_pkg.
module mm64a_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] operand,
    output logic        done,
    output logic [63:0] product
);
    import mm64a_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LL   = 4'b0010,
        ST_LH   = 4'b0100,
        ST_HL   = 4'b1000
    } mul_step_t;

    mul_step_t   step_reg, step_next;
    logic        done_reg, done_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] mx, my;
    logic [63:0] pp;

    // Partial products: aL*cL, then the two cross terms shifted up by 32.
    // The high-by-high term falls entirely above bit 63.
    always_comb
    begin
        mx = a_reg[31:0];
        my = MUL_CONST[31:0];
        unique case (step_reg)
            ST_LH:
            begin
                my = MUL_CONST[63:32];
            end
            ST_HL:
            begin
                mx = a_reg[63:32];
            end
            default:
            begin
                mx = a_reg[31:0];
            end
        endcase
    end

    assign pp = 64'(mx) * 64'(my);

    always_comb
    begin
        step_next = step_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        acc_next  = acc_reg;
        unique case (step_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    a_next    = operand;
                    step_next = ST_LL;
                end
            end
            ST_LL:
            begin
                acc_next  = pp;
                step_next = ST_LH;
            end
            ST_LH:
            begin
                acc_next  = acc_reg + {pp[31:0], 32'h0};
                step_next = ST_HL;
            end
            ST_HL:
            begin
                acc_next  = acc_reg + {pp[31:0], 32'h0};
                done_next = 1'b1;
                step_next = ST_IDLE;
            end
            default:
            begin
                step_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

/* sv/mm64a_dp.sv */
`timescale 1ns / 1ps
// Datapath: input capture, running hash, mixing word and result register.
// Driven by mm64a_ctrl commands; instantiates mm64a_mul, depends on mm64a_pkg.
module mm64a_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mm64a_pkg::dp_cmd_t    cmd,
    output mm64a_pkg::dp_status_t status,
    input  logic [31:0]           seed,
    input  logic [63:0]           data_word,
    input  logic [3:0]            bytes_valid,
    input  logic                  last_word,
    input  logic [30:0]           message_length,
    output logic [63:0]           hash_value
);
    import mm64a_pkg::*;

    logic [63:0] word_reg;
    logic [3:0]  nb_reg;
    logic        last_reg;
    logic [30:0] len_reg;
    logic [63:0] h_reg, h_next;
    logic [63:0] k_reg;
    logic [63:0] hash_reg;
    logic [63:0] tail_mask;
    logic [63:0] mul_operand;
    logic [63:0] mul_product;
    logic        mul_done;

    mm64a_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .operand (mul_operand),
        .done    (mul_done),
        .product (mul_product)
    );

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            tail_mask[8*i +: 8] = {8{4'(i) < nb_reg}};
        end
    end

    always_comb
    begin
        case (cmd.mul_src)
            SRC_LEN:  mul_operand = {33'd0, len_reg};
            SRC_WORD: mul_operand = word_reg;
            SRC_K:    mul_operand = k_reg;
            SRC_H:    mul_operand = h_reg;
            SRC_HFIN: mul_operand = h_reg ^ (h_reg >> MIX_SHIFT);
            default:  mul_operand = h_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.h_op)
            H_INIT:  h_next = {32'd0, seed} ^ mul_product;
            H_XORP:  h_next = h_reg ^ mul_product;
            H_TAIL:  h_next = h_reg ^ (word_reg & tail_mask);
            H_PROD:  h_next = mul_product;
            H_FIN:   h_next = mul_product ^ (mul_product >> MIX_SHIFT);
            default: h_next = h_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            word_reg <= data_word;
            // Counts above eight mean a full word.
            nb_reg   <= bytes_valid[3] ? BYTES_PER_WORD : bytes_valid;
            last_reg <= last_word;
            len_reg  <= message_length;
        end
        if (cmd.k_load)
        begin
            k_reg <= mul_product ^ (mul_product >> MIX_SHIFT);
        end
        if (cmd.out_load)
        begin
            hash_reg <= h_reg;
        end
        h_reg <= h_next;
    end

    assign status.mul_done = mul_done;
    assign status.nb_full  = nb_reg[3];
    assign status.nb_zero  = (nb_reg == 4'd0);
    assign status.last     = last_reg;
    assign hash_value      = hash_reg;

endmodule

/* sv/mm64a_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences the multiplies for one item and owns the handshakes.
// Talks to mm64a_dp through command and status structs; depends on mm64a_pkg.
module mm64a_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    output mm64a_pkg::dp_cmd_t    cmd,
    input  mm64a_pkg::dp_status_t status
);
    import mm64a_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_DISP    = 14'b00000000000010,
        S_INIT_GO = 14'b00000000000100,
        S_INIT_WT = 14'b00000000001000,
        S_K1_GO   = 14'b00000000010000,
        S_K1_WT   = 14'b00000000100000,
        S_K2_GO   = 14'b00000001000000,
        S_K2_WT   = 14'b00000010000000,
        S_TAIL    = 14'b00000100000000,
        S_HM_GO   = 14'b00001000000000,
        S_HM_WT   = 14'b00010000000000,
        S_F_GO    = 14'b00100000000000,
        S_F_WT    = 14'b01000000000000,
        S_OUT     = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   in_msg_reg, in_msg_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        in_msg_next    = in_msg_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.mul_src    = SRC_H;
        cmd.h_op       = H_HOLD;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = in_msg_reg ? S_DISP : S_INIT_GO;
                end
            end
            S_DISP:
            begin
                if (status.nb_full)
                begin
                    state_next = S_K1_GO;
                end
                else if (!status.nb_zero)
                begin
                    state_next = S_TAIL;
                end
                else if (status.last)
                begin
                    state_next = S_F_GO;
                end
                else
                begin
                    // An empty word that is not last leaves the hash alone.
                    in_msg_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_INIT_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_src   = SRC_LEN;
                state_next    = S_INIT_WT;
            end
            S_INIT_WT:
            begin
                if (status.mul_done)
                begin
                    cmd.h_op   = H_INIT;
                    state_next = S_DISP;
                end
            end
            S_K1_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_src   = SRC_WORD;
                state_next    = S_K1_WT;
            end
            S_K1_WT:
            begin
                if (status.mul_done)
                begin
                    cmd.k_load = 1'b1;
                    state_next = S_K2_GO;
                end
            end
            S_K2_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_src   = SRC_K;
                state_next    = S_K2_WT;
            end
            S_K2_WT:
            begin
                if (status.mul_done)
                begin
                    cmd.h_op   = H_XORP;
                    state_next = S_HM_GO;
                end
            end
            S_TAIL:
            begin
                cmd.h_op   = H_TAIL;
                state_next = S_HM_GO;
            end
            S_HM_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_src   = SRC_H;
                state_next    = S_HM_WT;
            end
            S_HM_WT:
            begin
                if (status.mul_done)
                begin
                    cmd.h_op = H_PROD;
                    if (status.last)
                    begin
                        state_next = S_F_GO;
                    end
                    else
                    begin
                        in_msg_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            S_F_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_src   = SRC_HFIN;
                state_next    = S_F_WT;
            end
            S_F_WT:
            begin
                if (status.mul_done)
                begin
                    cmd.h_op   = H_FIN;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // Wait until the result register is empty or being taken.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    in_msg_next    = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_msg_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_msg_reg    <= in_msg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* sv/murmur64a_hash.sv */
`timescale 1ns / 1ps
// MurmurHash64A over a stream of 64-bit little-endian message words.
// Input channel (in_valid/in_stall): data_word, bytes_valid, last_word and
// message_length; message_length is used only on the first item of a message.
// Output channel (out_valid/out_stall): hash_value, one item per message,
// given when the last word has been taken in.
// Every 64-bit multiply runs on one shared 32x32 multiplier in three steps.
// A full word costs three multiplies, a partial word one, the first word of a
// message one more, and the finish one more. in_stall is high while an item is
// being worked on.
// The result sits in an output register; a stalled receiver holds it, the next
// message keeps going, and only its own finish waits for the register to free.
// Reset clears the controller, drops out_valid and sets seed to 19820125.
// The seed register is read and written over the APB port at address 0.
module murmur64a_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] data_word,
    input  logic [3:0]  bytes_valid,
    input  logic        last_word,
    input  logic [30:0] message_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] hash_value
);
    import mm64a_pkg::*;

    localparam logic REG_SEED = 1'b0;

    logic [31:0] seed_reg, seed_next;
    dp_cmd_t     cmd;
    dp_status_t  status;
    logic        seed_wr;

    assign pready  = 1'b1;
    assign seed_wr = psel && penable && pwrite && (paddr[2] == REG_SEED);

    always_comb
    begin
        seed_next = seed_wr ? pwdata : seed_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
        end
        else
        begin
            seed_reg <= seed_next;
        end
    end

    assign prdata = (paddr[2] == REG_SEED) ? seed_reg : 32'd0;

    mm64a_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    mm64a_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .seed           (seed_reg),
        .data_word      (data_word),
        .bytes_valid    (bytes_valid),
        .last_word      (last_word),
        .message_length (message_length),
        .hash_value     (hash_value)
    );

endmodule
